FILE: rtl/ght_pkg.sv
// Shared constants, codes and control types for the generational handle table.
package ght_pkg;

   // Table geometry and field widths
   localparam int SLOTS    = 64;
   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int ID_W     = SLOT_W + 1;
   localparam int GEN_W    = 16;
   localparam int OBJ_W    = 32;
   localparam int TYPE_W   = 8;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;

   // Operation codes; the fourth code means nothing and is rejected
   typedef enum logic [KIND_W-1:0] {
      KIND_REGISTER = 2'd0,
      KIND_RELEASE  = 2'd1,
      KIND_GET      = 2'd2
   } kind_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_BADREF   = 2'd2,
      ST_MISMATCH = 2'd3
   } status_type;

   // Controller states
   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch request, launch slot read
      logic commit;    // check, write back, load response
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic rsp_free;  // response register can take a new result
   } stat_type;

endpackage

FILE: rtl/ght_if.sv
// Request and response channel interfaces of the handle table.
interface ght_req_if;
   logic                             valid;
   logic                             ready;
   logic [ght_pkg::KIND_W-1:0]       kind;
   logic [ght_pkg::ID_W-1:0]         handle_id;
   logic [ght_pkg::GEN_W-1:0]        handle_gen;
   logic [ght_pkg::TYPE_W-1:0]       type_id;
   logic [ght_pkg::OBJ_W-1:0]        object_value;

   modport source (output valid, kind, handle_id, handle_gen, type_id, object_value,
                   input ready);
   modport sink   (input valid, kind, handle_id, handle_gen, type_id, object_value,
                   output ready);
endinterface

interface ght_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ght_pkg::STATUS_W-1:0]     status;
   logic [ght_pkg::ID_W-1:0]         ref_id;
   logic [ght_pkg::GEN_W-1:0]        ref_gen;
   logic [ght_pkg::OBJ_W-1:0]        object_out;

   modport source (output valid, status, ref_id, ref_gen, object_out, input ready);
   modport sink   (input valid, status, ref_id, ref_gen, object_out, output ready);
endinterface

FILE: rtl/ght_ctrl.sv
// Controller state machine: sequences request capture and slot commit.
module ght_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ght_pkg::stat_type stat,
   output ght_pkg::cmd_type  cmd
);

   ght_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ght_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ght_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ght_pkg::S_EXEC;
            end
         end
         ght_pkg::S_EXEC: begin
            // hold until the response register is free
            if (stat.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ght_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ght_pkg::S_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/ght_datapath.sv
// Datapath: slot memory, live bits, high-water mark, checks and response register.
module ght_datapath (
   input  logic              clock,
   input  logic              reset,
   ght_req_if.sink           req,
   ght_rsp_if.source         rsp,
   input  ght_pkg::cmd_type  cmd,
   output ght_pkg::stat_type stat
);

   typedef struct packed {
      logic [ght_pkg::TYPE_W-1:0] type_id;
      logic [ght_pkg::OBJ_W-1:0]  object_value;
      logic [ght_pkg::GEN_W-1:0]  generation;
   } entry_type;

   // Slot memory, one write and one registered read port
   entry_type                    mem [ght_pkg::SLOTS];
   entry_type                    rd_ff;
   entry_type                    wr_data;
   logic                         mem_we;
   logic [ght_pkg::SLOT_W-1:0]   rd_addr;

   // Control state
   logic [ght_pkg::SLOTS-1:0]    live_ff, live_in;
   logic [ght_pkg::ID_W-1:0]     hw_ff, hw_in;
   logic                         rsp_valid_ff;

   // Captured request
   logic [ght_pkg::KIND_W-1:0]   kind_ff;
   logic [ght_pkg::GEN_W-1:0]    gen_ff;
   logic [ght_pkg::TYPE_W-1:0]   type_ff;
   logic [ght_pkg::OBJ_W-1:0]    obj_ff;
   logic [ght_pkg::SLOT_W-1:0]   addr_ff, addr_in;
   logic                         fresh_ff, full_ff, ref_pre_ff;

   // Response register
   logic [ght_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [ght_pkg::ID_W-1:0]     ref_id_ff, ref_id_in;
   logic [ght_pkg::GEN_W-1:0]    ref_gen_ff, ref_gen_in;
   logic [ght_pkg::OBJ_W-1:0]    obj_out_ff, obj_out_in;

   // Lookup terms
   logic [ght_pkg::SLOT_W-1:0]   free_ix;
   logic [ght_pkg::ID_W-1:0]     id_m1;
   logic [ght_pkg::SLOT_W-1:0]   id_ix;
   logic                         id_ok;
   logic                         gen_match;
   logic                         reg_fresh_ok;

   // Lowest slot that is not live; slots at or above the mark are never live
   always_comb begin
      free_ix = '0;
      for (int i = ght_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            free_ix = ght_pkg::SLOT_W'(i);
         end
      end
   end

   // Reference range check at capture time
   assign id_m1   = req.handle_id - ght_pkg::ID_W'(1);
   assign id_ix   = id_m1[ght_pkg::SLOT_W-1:0];
   assign id_ok   = (req.handle_id != '0) && (req.handle_id <= hw_ff);
   assign addr_in = (req.kind == ght_pkg::KIND_REGISTER) ? free_ix : id_ix;
   assign rd_addr = cmd.capture ? addr_in : addr_ff;

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff    <= req.kind;
         gen_ff     <= req.handle_gen;
         type_ff    <= req.type_id;
         obj_ff     <= req.object_value;
         addr_ff    <= addr_in;
         fresh_ff   <= ({1'b0, free_ix} == hw_ff);
         full_ff    <= &live_ff;
         ref_pre_ff <= id_ok && live_ff[id_ix];
      end
   end

   // Slot memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign gen_match = (rd_ff.generation == gen_ff);

   // Checks and write-back for the captured operation
   always_comb begin
      status_in    = ght_pkg::ST_BADREF;
      ref_id_in    = '0;
      ref_gen_in   = '0;
      obj_out_in   = '0;
      mem_we       = 1'b0;
      wr_data      = rd_ff;
      live_in      = live_ff;
      hw_in        = hw_ff;
      reg_fresh_ok = 1'b0;
      case (kind_ff)
         ght_pkg::KIND_REGISTER: begin
            if (type_ff == '0) begin
               status_in = ght_pkg::ST_BADREF;
            end else if (full_ff) begin
               status_in = ght_pkg::ST_FULL;
            end else begin
               status_in            = ght_pkg::ST_OK;
               wr_data.type_id      = type_ff;
               wr_data.object_value = obj_ff;
               if (fresh_ff) begin
                  wr_data.generation = ght_pkg::GEN_W'(1);
                  reg_fresh_ok       = 1'b1;
               end
               mem_we     = cmd.commit;
               ref_id_in  = {1'b0, addr_ff} + ght_pkg::ID_W'(1);
               ref_gen_in = wr_data.generation;
               if (cmd.commit) begin
                  live_in[addr_ff] = 1'b1;
                  if (fresh_ff) begin
                     hw_in = hw_ff + ght_pkg::ID_W'(1);
                  end
               end
            end
         end
         ght_pkg::KIND_RELEASE: begin
            if (ref_pre_ff && gen_match) begin
               status_in          = ght_pkg::ST_OK;
               wr_data.generation = rd_ff.generation + ght_pkg::GEN_W'(1);
               mem_we             = cmd.commit;
               if (cmd.commit) begin
                  live_in[addr_ff] = 1'b0;
               end
            end
         end
         ght_pkg::KIND_GET: begin
            if (ref_pre_ff && gen_match && (type_ff != '0)) begin
               if (rd_ff.type_id != type_ff) begin
                  status_in = ght_pkg::ST_MISMATCH;
               end else begin
                  status_in  = ght_pkg::ST_OK;
                  obj_out_in = rd_ff.object_value;
               end
            end
         end
         default: begin
            status_in = ght_pkg::ST_BADREF;
         end
      endcase
   end

   // Live bits, high-water mark and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff      <= '0;
         hw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
         hw_ff   <= hw_in;
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff  <= status_in;
         ref_id_ff  <= ref_id_in;
         ref_gen_ff <= ref_gen_in;
         obj_out_ff <= obj_out_in;
      end
   end

   assign stat.rsp_free  = !rsp_valid_ff || rsp.ready;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = status_ff;
   assign rsp.ref_id     = ref_id_ff;
   assign rsp.ref_gen    = ref_gen_ff;
   assign rsp.object_out = obj_out_ff;

   // High-water mark never passes the table size
   a_hw_range: assert property (@(posedge clock) disable iff (reset)
      hw_ff <= ght_pkg::ID_W'(ght_pkg::SLOTS))
      else $error("high-water mark beyond table size");

   // No slot at or above the high-water mark is live
   a_live_below_hw: assert property (@(posedge clock) disable iff (reset)
      (live_ff >> hw_ff) == '0)
      else $error("live slot above high-water mark");

   // A fresh-slot register advances the mark by exactly one
   a_hw_step: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && reg_fresh_ok |=> hw_ff == $past(hw_ff) + ght_pkg::ID_W'(1))
      else $error("high-water mark did not advance");

   // A commit never overwrites a response that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> stat.rsp_free)
      else $error("commit while response held");

endmodule

FILE: rtl/generational_handle_table_core.sv
// Top level of the generational handle table.
// Each request (register, release or get) runs as a capture step that reads the
// addressed slot's type, object word and generation from the slot memory through
// its registered read port, and then a commit step that checks the reference and
// writes the slot back. The free slot for a register comes from a priority encoder
// over the live bits, which sit in flip-flops cleared by reset, so the table is
// ready right after reset with no clearing pass. A new request is taken while
// the previous response still waits on the response channel; the commit step
// stalls only while that response is still held.
module generational_handle_table_core (
   input  logic      clock,
   input  logic      reset,
   ght_req_if.sink   req_chan,
   ght_rsp_if.source rsp_chan
);

   ght_pkg::cmd_type  cmd;
   ght_pkg::stat_type stat;
   logic              req_ready;

   assign req_chan.ready = req_ready;

   // Sequencer
   ght_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Slot storage and checks
   ght_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .rsp   (rsp_chan),
      .cmd   (cmd),
      .stat  (stat)
   );

endmodule
